// ===== hw/rtl/ldfb_pkg.sv =====
// ----------------------------------------------------------------------------
// ldfb_pkg: shared types for the line drawing framebuffer
// Request kinds, controller states and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package ldfb_pkg;

    // Pixel rows held by one store byte, and the shift that selects the page
    localparam int PAGE_ROWS  = 8;
    localparam int PAGE_SHIFT = 3;

    typedef enum logic [1:0] {
        KIND_PLOT  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP_A,
        S_SETUP_B,
        S_PIX_RD,
        S_PIX_WR,
        S_RD_MEM,
        S_RD_OUT
    } state_t;

    typedef struct packed {
        logic load;       // capture request fields
        logic setup_a;    // deltas and magnitudes
        logic setup_b;    // major axis, start point, error terms
        logic pix_read;   // fetch the byte under the current pixel
        logic pix_write;  // write back the modified byte
        logic advance;    // step to the next pixel of the walk
        logic clr_write;  // zero one store byte, bump the sweep counter
        logic clr_rst;    // rewind the sweep counter
        logic rd_issue;   // fetch the byte for a read request
        logic out_load;   // move fetched byte into the result register
    } cmd_t;

    typedef struct packed {
        logic on_screen;  // current pixel lies inside the screen
        logic more;       // walk has pixels left after the current one
        logic clr_last;   // sweep counter is at the last store byte
    } status_t;

endpackage

// ===== hw/rtl/line_drawing_framebuffer_core.sv =====
// ----------------------------------------------------------------------------
// line_drawing_framebuffer_core: monochrome line drawing engine
// Page-organised framebuffer with plot, line, clear and byte read requests.
// ----------------------------------------------------------------------------
// One request is handled at a time; the cost is set by the read-modify-write
// of the frame store. After reset the block sweeps the store to zero, one byte
// a cycle (PAGES*SCREEN_W bytes, 1024 by default), before in_ready rises. A
// clear runs the same sweep. A read's result waits in an output register, so
// the next request is accepted while it is pending. Plot and line run the
// setup states S_SETUP_A and S_SETUP_B, then a store read and write for each
// pixel on screen and a skip step for each pixel off screen along the major
// axis (|major delta| + 1 pixels).
module line_drawing_framebuffer_core #(
    parameter int SCREEN_W   = 128,
    parameter int SCREEN_H   = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic                         color,
    input  logic [9:0]                   read_address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   read_data
);

    ldfb_pkg::cmd_t    cmd;
    ldfb_pkg::status_t status;

    ldfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    ldfb_datapath #(
        .SCREEN_W   (SCREEN_W),
        .SCREEN_H   (SCREEN_H),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .color        (color),
        .read_address (read_address),
        .read_data    (read_data)
    );

endmodule

// ===== hw/rtl/ldfb_datapath.sv =====
// ----------------------------------------------------------------------------
// ldfb_datapath: framebuffer store and Bresenham walker
// Holds the page-organised store, the line setup registers, the error term
// walker, the clear sweep counter and the read result register.
// ----------------------------------------------------------------------------
module ldfb_datapath #(
    parameter int SCREEN_W   = 128,
    parameter int SCREEN_H   = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ldfb_pkg::cmd_t               cmd,
    output ldfb_pkg::status_t            status,
    input  logic [1:0]                   kind,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic                         color,
    input  logic [9:0]                   read_address,
    output logic [7:0]                   read_data
);

    localparam int PAGES       = (SCREEN_H + ldfb_pkg::PAGE_ROWS - 1) / ldfb_pkg::PAGE_ROWS;
    localparam int STORE_BYTES = PAGES * SCREEN_W;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int X_W         = $clog2(SCREEN_W);
    localparam int EW          = COORD_BITS + 3;

    // request fields
    logic signed [COORD_BITS-1:0] xs_reg, ys_reg, xe_reg, ye_reg;
    logic                         color_reg;
    logic [9:0]                   raddr_reg;

    // setup
    logic signed [EW-1:0] adx_reg, ady_reg;
    logic                 dx_neg_reg, dy_neg_reg;

    // walker
    logic signed [COORD_BITS-1:0] maj_reg, min_reg, stop_reg;
    logic signed [EW-1:0]         err_reg, inc_a_reg, inc_b_reg;
    logic                         ymaj_reg, step_neg_reg;

    // store access
    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        mem_q_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        mask_reg;
    logic              in_range_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [7:0]        read_data_reg;

    logic signed [EW-1:0]         dx, dy;
    logic                         ymaj;
    logic signed [EW-1:0]         ms, mj;
    logic signed [COORD_BITS-1:0] cx, cy;
    logic [ADDR_W-1:0]            pix_addr, rd_addr;
    logic                         tie;

    assign dx   = EW'(xe_reg) - EW'(xs_reg);
    assign dy   = EW'(ye_reg) - EW'(ys_reg);
    assign ymaj = ady_reg > adx_reg;
    assign ms   = ymaj ? adx_reg : ady_reg;
    assign mj   = ymaj ? ady_reg : adx_reg;

    assign cx = ymaj_reg ? min_reg : maj_reg;
    assign cy = ymaj_reg ? maj_reg : min_reg;

    assign pix_addr = ADDR_W'(cx[X_W-1:0])
                    + ADDR_W'(cy[5:ldfb_pkg::PAGE_SHIFT]) * ADDR_W'(SCREEN_W);
    assign rd_addr  = cmd.pix_read ? pix_addr : ADDR_W'(raddr_reg);

    // y-major walk steps the minor axis only on a strictly positive error
    assign tie = ymaj_reg ? (err_reg <= 0) : (err_reg < 0);

    assign status.on_screen = (cx >= 0) && (int'(cx) < SCREEN_W)
                           && (cy >= 0) && (int'(cy) < SCREEN_H);
    assign status.more      = maj_reg < stop_reg;
    assign status.clr_last  = clr_cnt_reg == ADDR_W'(STORE_BYTES - 1);

    assign read_data = read_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xs_reg    <= x_start;
            ys_reg    <= y_start;
            color_reg <= color;
            raddr_reg <= read_address;
            // a plot is a line of one point
            if (kind == ldfb_pkg::KIND_PLOT)
            begin
                xe_reg <= x_start;
                ye_reg <= y_start;
            end
            else
            begin
                xe_reg <= x_end;
                ye_reg <= y_end;
            end
        end

        if (cmd.setup_a)
        begin
            adx_reg    <= dx[EW-1] ? -dx : dx;
            ady_reg    <= dy[EW-1] ? -dy : dy;
            dx_neg_reg <= dx[EW-1];
            dy_neg_reg <= dy[EW-1];
        end

        if (cmd.setup_b)
        begin
            ymaj_reg     <= ymaj;
            step_neg_reg <= dx_neg_reg != dy_neg_reg;
            err_reg      <= (ms <<< 1) - mj;
            inc_a_reg    <= ms <<< 1;
            inc_b_reg    <= (ms - mj) <<< 1;
            // start from the endpoint with the smaller major coordinate
            if (!ymaj)
            begin
                if (!dx_neg_reg)
                begin
                    maj_reg  <= xs_reg;
                    min_reg  <= ys_reg;
                    stop_reg <= xe_reg;
                end
                else
                begin
                    maj_reg  <= xe_reg;
                    min_reg  <= ye_reg;
                    stop_reg <= xs_reg;
                end
            end
            else
            begin
                if (!dy_neg_reg)
                begin
                    maj_reg  <= ys_reg;
                    min_reg  <= xs_reg;
                    stop_reg <= ye_reg;
                end
                else
                begin
                    maj_reg  <= ye_reg;
                    min_reg  <= xe_reg;
                    stop_reg <= ys_reg;
                end
            end
        end
        else if (cmd.advance)
        begin
            maj_reg <= maj_reg + COORD_BITS'(1);
            if (tie)
            begin
                err_reg <= err_reg + inc_a_reg;
            end
            else
            begin
                err_reg <= err_reg + inc_b_reg;
                min_reg <= step_neg_reg ? min_reg - COORD_BITS'(1)
                                        : min_reg + COORD_BITS'(1);
            end
        end

        if (cmd.pix_read)
        begin
            addr_reg <= pix_addr;
            mask_reg <= 8'(1) << cy[2:0];
        end

        if (cmd.rd_issue)
        begin
            in_range_reg <= 32'(raddr_reg) < STORE_BYTES;
        end

        if (cmd.out_load)
        begin
            read_data_reg <= in_range_reg ? mem_q_reg : 8'd0;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_write)
        begin
            mem[clr_cnt_reg] <= 8'd0;
        end
        else if (cmd.pix_write)
        begin
            mem[addr_reg] <= color_reg ? (mem_q_reg | mask_reg) : (mem_q_reg & ~mask_reg);
        end

        if (cmd.pix_read || cmd.rd_issue)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_rst)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_write)
        begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

endmodule

// ===== hw/rtl/ldfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ldfb_ctrl: request sequencer for the line drawing framebuffer
// Accepts requests, runs the clear sweep, the pixel read-modify-write walk
// and the read path, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ldfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    output logic              out_valid,
    input  logic              out_ready,
    output ldfb_pkg::cmd_t    cmd,
    input  ldfb_pkg::status_t status
);

    ldfb_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = state_reg == ldfb_pkg::S_IDLE;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ldfb_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ldfb_pkg::S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ldfb_pkg::S_IDLE;
                end
            end
            ldfb_pkg::S_IDLE:
            begin
                cmd.clr_rst = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (ldfb_pkg::kind_t'(kind))
                        ldfb_pkg::KIND_PLOT,
                        ldfb_pkg::KIND_LINE:  state_next = ldfb_pkg::S_SETUP_A;
                        ldfb_pkg::KIND_CLEAR: state_next = ldfb_pkg::S_CLEAR;
                        ldfb_pkg::KIND_READ:  state_next = ldfb_pkg::S_RD_MEM;
                        default:              state_next = ldfb_pkg::S_IDLE;
                    endcase
                end
            end
            ldfb_pkg::S_SETUP_A:
            begin
                cmd.setup_a = 1'b1;
                state_next  = ldfb_pkg::S_SETUP_B;
            end
            ldfb_pkg::S_SETUP_B:
            begin
                cmd.setup_b = 1'b1;
                state_next  = ldfb_pkg::S_PIX_RD;
            end
            ldfb_pkg::S_PIX_RD:
            begin
                if (status.on_screen)
                begin
                    cmd.pix_read = 1'b1;
                    state_next   = ldfb_pkg::S_PIX_WR;
                end
                else if (status.more)
                begin
                    // skip off-screen pixel
                    cmd.advance = 1'b1;
                end
                else
                begin
                    state_next = ldfb_pkg::S_IDLE;
                end
            end
            ldfb_pkg::S_PIX_WR:
            begin
                cmd.pix_write = 1'b1;
                if (status.more)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ldfb_pkg::S_PIX_RD;
                end
                else
                begin
                    state_next = ldfb_pkg::S_IDLE;
                end
            end
            ldfb_pkg::S_RD_MEM:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ldfb_pkg::S_RD_OUT;
            end
            ldfb_pkg::S_RD_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ldfb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ldfb_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pix_write |-> $past(cmd.pix_read))
        else $error("pixel write without preceding read");

    a_advance_has_more: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> status.more)
        else $error("walk advanced past its end");

    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ldfb_pkg::S_RD_OUT && out_valid_reg && !out_ready)
        |=> (state_reg == ldfb_pkg::S_RD_OUT && out_valid_reg))
        else $error("pending result overwritten");

    a_read_goes_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == ldfb_pkg::KIND_READ)
        |=> ##1 state_reg == ldfb_pkg::S_RD_OUT)
        else $error("read request did not reach the result stage");
`endif

endmodule

// ===== test/tb_line_drawing_framebuffer_core.sv =====
// ----------------------------------------------------------------------------
// tb_line_drawing_framebuffer_core: self-checking bench for the line engine
// Keeps a shadow copy of the page-organised frame store, updates it for every
// accepted plot, line and clear request, and checks each byte read back.
// Directed corner cases come first, then random requests under varying
// back-pressure on both channels, then a sparse readback of the whole store.
// ----------------------------------------------------------------------------
module tb_line_drawing_framebuffer_core;

    localparam int SCREEN_W   = 128;
    localparam int SCREEN_H   = 64;
    localparam int COORD_BITS = 12;
    localparam int STORE_SIZE = SCREEN_W
                              * ((SCREEN_H + ldfb_pkg::PAGE_ROWS - 1) / ldfb_pkg::PAGE_ROWS);

    // Shadow of the frame store plus the bytes that pending reads must return
    class frame_mirror;
        logic [7:0] store [STORE_SIZE];
        logic [7:0] read_bytes_due [$];
        int         mismatches;

        function new();
            wipe();
            mismatches = 0;
        endfunction

        function void wipe();
            foreach (store[i])
                store[i] = 8'h00;
        endfunction

        function int pending();
            return read_bytes_due.size();
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        function void set_pixel(int x, int y, bit on);
            int addr;
            if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H)
                return;
            addr = x + (y / ldfb_pkg::PAGE_ROWS) * SCREEN_W;
            if (on)
                store[addr][y % ldfb_pkg::PAGE_ROWS] = 1'b1;
            else
                store[addr][y % ldfb_pkg::PAGE_ROWS] = 1'b0;
        endfunction

        function void draw_line(int xa, int ya, int xb, int yb, bit on);
            int dx, dy, adx, ady, err, cx, cy, stop, step, lo, hi;
            dx = xb - xa;
            dy = yb - ya;
            if (dx == 0)
            begin
                lo = (ya < yb) ? ya : yb;
                hi = (ya < yb) ? yb : ya;
                for (cy = lo; cy <= hi; cy++)
                    set_pixel(xa, cy, on);
                return;
            end
            if (dy == 0)
            begin
                lo = (xa < xb) ? xa : xb;
                hi = (xa < xb) ? xb : xa;
                for (cx = lo; cx <= hi; cx++)
                    set_pixel(cx, ya, on);
                return;
            end
            adx  = (dx < 0) ? -dx : dx;
            ady  = (dy < 0) ? -dy : dy;
            step = ((dx < 0) == (dy < 0)) ? 1 : -1;
            if (ady <= adx)
            begin
                // x-major: start at the smaller x, step y when the error is not negative
                err = 2 * ady - adx;
                if (dx >= 0)
                begin
                    cx = xa; cy = ya; stop = xb;
                end
                else
                begin
                    cx = xb; cy = yb; stop = xa;
                end
                set_pixel(cx, cy, on);
                while (cx < stop)
                begin
                    cx++;
                    if (err < 0)
                        err += 2 * ady;
                    else
                    begin
                        cy  += step;
                        err += 2 * (ady - adx);
                    end
                    set_pixel(cx, cy, on);
                end
            end
            else
            begin
                // y-major: the tie goes the other way here
                err = 2 * adx - ady;
                if (dy >= 0)
                begin
                    cx = xa; cy = ya; stop = yb;
                end
                else
                begin
                    cx = xb; cy = yb; stop = ya;
                end
                set_pixel(cx, cy, on);
                while (cy < stop)
                begin
                    cy++;
                    if (err <= 0)
                        err += 2 * adx;
                    else
                    begin
                        cx  += step;
                        err += 2 * (adx - ady);
                    end
                    set_pixel(cx, cy, on);
                end
            end
        endfunction

        function void apply_request(ldfb_pkg::kind_t k, int xs, int ys, int xe, int ye,
                                    bit on, int addr);
            case (k)
                ldfb_pkg::KIND_PLOT:  set_pixel(xs, ys, on);
                ldfb_pkg::KIND_LINE:  draw_line(xs, ys, xe, ye, on);
                ldfb_pkg::KIND_CLEAR: wipe();
                // an address past the store reads as zero
                default:              read_bytes_due.push_back(
                                          (addr < STORE_SIZE) ? store[addr] : 8'h00);
            endcase
        endfunction

        task check_read_data(logic [7:0] data);
            logic [7:0] want;
            if (read_bytes_due.size() == 0)
            begin
                report($sformatf("read_data %02h with no read pending", data));
                return;
            end
            want = read_bytes_due.pop_front();
            if (data !== want)
                report($sformatf("read_data %02h, expected %02h", data, want));
        endtask
    endclass

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         in_ready;
    logic [1:0]                   kind         = ldfb_pkg::KIND_PLOT;
    logic signed [COORD_BITS-1:0] x_start      = '0;
    logic signed [COORD_BITS-1:0] y_start      = '0;
    logic signed [COORD_BITS-1:0] x_end        = '0;
    logic signed [COORD_BITS-1:0] y_end        = '0;
    logic                         color        = 1'b0;
    logic [9:0]                   read_address = '0;
    logic                         out_valid;
    logic                         out_ready    = 1'b0;
    logic [7:0]                   read_data;

    frame_mirror mirror = new();
    int          send_idle_pct = 24;
    int          recv_idle_pct = 66;
    int          last_x = 0;
    int          last_y = 0;

    line_drawing_framebuffer_core #(
        .SCREEN_W   (SCREEN_W),
        .SCREEN_H   (SCREEN_H),
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .color        (color),
        .read_address (read_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                mirror.apply_request(ldfb_pkg::kind_t'(kind), x_start, y_start, x_end,
                                     y_end, color, read_address);
            if (out_valid && out_ready)
                mirror.check_read_data(read_data);
        end
    end

    function automatic int any_coord();
        int v;
        v = $urandom_range((1 << COORD_BITS) - 1);
        if (v >= (1 << (COORD_BITS - 1)))
            v -= (1 << COORD_BITS);
        return v;
    endfunction

    // Call right after a rising edge; returns at the edge that takes the request
    task automatic send_request(ldfb_pkg::kind_t k, int xs, int ys, int xe, int ye,
                                bit on, int addr);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        x_start      <= xs[COORD_BITS-1:0];
        y_start      <= ys[COORD_BITS-1:0];
        x_end        <= xe[COORD_BITS-1:0];
        y_end        <= ye[COORD_BITS-1:0];
        color        <= on;
        read_address <= addr[9:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic plot(int x, int y, bit on);
        send_request(ldfb_pkg::KIND_PLOT, x, y, any_coord(), any_coord(), on,
                     $urandom_range(1023));
    endtask

    task automatic line(int xa, int ya, int xb, int yb, bit on);
        send_request(ldfb_pkg::KIND_LINE, xa, ya, xb, yb, on, $urandom_range(1023));
    endtask

    task automatic read_byte(int addr);
        send_request(ldfb_pkg::KIND_READ, any_coord(), any_coord(), any_coord(),
                     any_coord(), 1'($urandom_range(1)), addr);
    endtask

    task automatic wait_for_reads();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        int r, xa, ya, xb, yb, nx, ny;
        bit on;
        r  = $urandom_range(99);
        on = ($urandom_range(99) < 70);
        if ($urandom_range(99) < 85)
        begin
            xa = $urandom_range(SCREEN_W + 7) - 4;
            ya = $urandom_range(SCREEN_H + 7) - 4;
        end
        else
        begin
            xa = any_coord();
            ya = any_coord();
        end
        if (r < 2)
            send_request(ldfb_pkg::KIND_CLEAR, any_coord(), any_coord(), any_coord(),
                         any_coord(), on, $urandom_range(1023));
        else if (r < 22)
        begin
            plot(xa, ya, on);
            last_x = xa;
            last_y = ya;
        end
        else if (r < 55)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                xb = $urandom_range(SCREEN_W + 39) - 20;
                yb = $urandom_range(SCREEN_H + 39) - 20;
            end
            else if (r < 60)
            begin
                xb = xa;
                yb = $urandom_range(SCREEN_H + 7) - 4;
            end
            else if (r < 75)
            begin
                xb = $urandom_range(SCREEN_W + 7) - 4;
                yb = ya;
            end
            else if (r < 96)
            begin
                xb = xa + $urandom_range(8) - 4;
                yb = ya + $urandom_range(8) - 4;
            end
            else
            begin
                // hold the walk long: far endpoints put long runs of off-screen pixels into the walk
                xb = any_coord();
                yb = any_coord();
            end
            line(xa, ya, xb, yb, on);
            last_x = xb;
            last_y = yb;
        end
        else if ($urandom_range(1))
        begin
            // aim near the last drawn point so reads see fresh pixels
            nx = last_x + $urandom_range(6) - 3;
            ny = last_y;
            nx = (nx < 0) ? 0 : (nx >= SCREEN_W) ? SCREEN_W - 1 : nx;
            ny = (ny < 0) ? 0 : (ny >= SCREEN_H) ? SCREEN_H - 1 : ny;
            read_byte(nx + (ny / ldfb_pkg::PAGE_ROWS) * SCREEN_W);
        end
        else
            read_byte($urandom_range(STORE_SIZE - 1));
    endtask

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int a;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners, off-screen pixels and the line special cases
        plot(0, 0, 1'b1);
        plot(SCREEN_W - 1, SCREEN_H - 1, 1'b1);
        plot(SCREEN_W - 1, 0, 1'b1);
        plot(0, SCREEN_H - 1, 1'b1);
        plot(-1, 5, 1'b1);
        plot(SCREEN_W, 5, 1'b1);
        plot(5, SCREEN_H, 1'b1);
        plot(-2048, 2047, 1'b1);
        line(3, 10, 3, 2, 1'b1);
        line(100, 20, 90, 20, 1'b1);
        line(10, 10, 10, 10, 1'b1);
        line(0, 0, SCREEN_W - 1, SCREEN_H - 1, 1'b1);
        line(20, 60, 25, 5, 1'b1);
        line(40, 40, 30, 45, 1'b1);
        line(50, 30, 54, 32, 1'b1);
        line(60, 30, 62, 34, 1'b1);
        line(-10, -5, SCREEN_W + 12, SCREEN_H + 6, 1'b1);
        line(2047, -2048, -2048, 2047, 1'b1);
        line(0, SCREEN_H - 1, SCREEN_W - 1, SCREEN_H - 1, 1'b0);
        plot(0, 0, 1'b0);
        read_byte(0);
        read_byte(SCREEN_W - 1);
        read_byte(STORE_SIZE - SCREEN_W);
        read_byte(STORE_SIZE - 1);
        send_request(ldfb_pkg::KIND_CLEAR, 0, 0, 0, 0, 1'b1, 0);
        read_byte(STORE_SIZE - 1);

        repeat (500) random_request();
        wait_for_reads();

        send_idle_pct = 66;
        recv_idle_pct = 24;
        repeat (500) random_request();
        wait_for_reads();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (350) random_request();
        for (a = $urandom_range(3); a < STORE_SIZE; a += 4)
            read_byte(a);

        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.pending() != 0 || !in_ready)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mirror.mismatches == 0 && mirror.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
